// ===== rtl/core/wavhc_pkg.sv =====
// Package for the WAV header check and unpack block.
// Holds the tags, the result and error codes, the register map and shared types.
// No dependencies.
package wavhc_pkg;

    localparam int SIZE_FIELD_BITS_DEF = 32;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_RIFF      = 3'd1;
    localparam logic [2:0] ERR_WAVE      = 3'd2;
    localparam logic [2:0] ERR_CHUNK_BIG = 3'd3;
    localparam logic [2:0] ERR_HDR_LIMIT = 3'd4;
    localparam logic [2:0] ERR_FORMAT    = 3'd5;
    localparam logic [2:0] ERR_DATA_SIZE = 3'd6;

    localparam logic [1:0] REG_EXPECTED_RATE   = 2'd0;
    localparam logic [1:0] REG_MAX_DATA_BYTES  = 2'd1;
    localparam logic [1:0] REG_MAX_CHUNK_BYTES = 2'd2;
    localparam logic [1:0] REG_HEADER_LIMIT    = 2'd3;

    localparam logic [31:0] RST_EXPECTED_RATE   = 32'd16000;
    localparam logic [23:0] RST_MAX_DATA_BYTES  = 24'd5760000;
    localparam logic [11:0] RST_MAX_CHUNK_BYTES = 12'd1024;
    localparam logic [15:0] RST_HEADER_LIMIT    = 16'd4096;

    typedef struct packed {
        logic [31:0] expected_rate;
        logic [23:0] max_data_bytes;
        logic [11:0] max_chunk_bytes;
        logic [15:0] header_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         error_code;
        logic [23:0]        data_bytes;
        logic signed [15:0] sample;
        logic               last;
    } res_t;

endpackage

// ===== rtl/core/wavhc_cfg.sv =====
// Configuration register bank of the WAV header check and unpack block.
// Depends on wavhc_pkg (register map, reset values, cfg_t).
module wavhc_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [31:0]         wr_data,
    output wavhc_pkg::cfg_t     cfg
);

    wavhc_pkg::cfg_t cfg_reg;
    wavhc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                wavhc_pkg::REG_EXPECTED_RATE:   cfg_next.expected_rate   = wr_data;
                wavhc_pkg::REG_MAX_DATA_BYTES:  cfg_next.max_data_bytes  = wr_data[23:0];
                wavhc_pkg::REG_MAX_CHUNK_BYTES: cfg_next.max_chunk_bytes = wr_data[11:0];
                wavhc_pkg::REG_HEADER_LIMIT:    cfg_next.header_limit    = wr_data[15:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_rate   <= wavhc_pkg::RST_EXPECTED_RATE;
            cfg_reg.max_data_bytes  <= wavhc_pkg::RST_MAX_DATA_BYTES;
            cfg_reg.max_chunk_bytes <= wavhc_pkg::RST_MAX_CHUNK_BYTES;
            cfg_reg.header_limit    <= wavhc_pkg::RST_HEADER_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/wavhc_parse.sv =====
// Parser state and single-step next-state logic for one file byte.
// Depends on wavhc_pkg (tags, codes, cfg_t, res_t).
module wavhc_parse
#(
    parameter int SIZE_FIELD_BITS = wavhc_pkg::SIZE_FIELD_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  logic [7:0]          byte_in,
    input  logic                first_in,
    input  wavhc_pkg::cfg_t     cfg,
    output logic                res_valid,
    output wavhc_pkg::res_t     res
);

    localparam logic [2:0] PH_RIFF = 3'd0;
    localparam logic [2:0] PH_CHDR = 3'd1;
    localparam logic [2:0] PH_BODY = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_IDLE = 3'd4;

    logic [2:0]  phase_reg, phase_next, e_phase;
    logic [3:0]  fp_reg, fp_next, e_fp;
    logic [31:0] tag_reg, tag_next, e_tag;
    logic [31:0] cl_reg, cl_next, e_cl;
    logic [4:0]  bp_reg, bp_next, e_bp;     // saturates at 16, only the first 16 matter
    logic [15:0] hc_reg, hc_next, e_hc;
    logic        fg_reg, fg_next, e_fg;
    logic        in_fmt_reg, in_fmt_next, e_in_fmt;
    logic        fso_reg, fso_next, e_fso;
    logic [63:0] cap_reg, cap_next, e_cap;
    logic [15:0] bits_reg, bits_next, e_bits;
    logic [23:0] left_reg, left_next, e_left;
    logic [7:0]  low_reg, low_next, e_low;

    logic [31:0] size_c;
    logic        over_c;
    logic [15:0] hc8_c;
    logic [12:0] len_c;
    logic [17:0] hsum_c;
    logic [31:0] tag_sh_c;

    always_comb
    begin
        // a first mark restarts parsing on this very byte
        e_phase  = first_in ? PH_RIFF : phase_reg;
        e_fp     = first_in ? 4'd0    : fp_reg;
        e_tag    = first_in ? 32'd0   : tag_reg;
        e_cl     = first_in ? 32'd0   : cl_reg;
        e_bp     = first_in ? 5'd0    : bp_reg;
        e_hc     = first_in ? 16'd0   : hc_reg;
        e_fg     = first_in ? 1'b0    : fg_reg;
        e_in_fmt = first_in ? 1'b0    : in_fmt_reg;
        e_fso    = first_in ? 1'b0    : fso_reg;
        e_cap    = first_in ? 64'd0   : cap_reg;
        e_bits   = first_in ? 16'd0   : bits_reg;
        e_left   = first_in ? 24'd0   : left_reg;
        e_low    = first_in ? 8'd0    : low_reg;

        phase_next  = e_phase;
        fp_next     = e_fp;
        tag_next    = e_tag;
        cl_next     = e_cl;
        bp_next     = e_bp;
        hc_next     = e_hc;
        fg_next     = e_fg;
        in_fmt_next = e_in_fmt;
        fso_next    = e_fso;
        cap_next    = e_cap;
        bits_next   = e_bits;
        left_next   = e_left;
        low_next    = e_low;

        res_valid = 1'b0;
        res       = '0;

        tag_sh_c = {e_tag[23:0], byte_in};
        size_c   = e_cl | ({24'd0, byte_in} << {e_fp[1:0], 3'b000});
        over_c   = (({32'd0, size_c} >> SIZE_FIELD_BITS) != 64'd0);
        hc8_c    = (e_hc > 16'd65527) ? 16'hFFFF : e_hc + 16'd8;
        len_c    = {1'b0, size_c[11:0]} + {12'd0, size_c[0]};
        hsum_c   = {2'b00, e_hc} + 18'd8 + {5'd0, len_c};

        unique case (e_phase)
            PH_RIFF:
            begin
                tag_next = tag_sh_c;
                if (e_fp == 4'd3 && tag_sh_c != wavhc_pkg::TAG_RIFF)
                begin
                    phase_next = PH_IDLE;
                    res_valid  = 1'b1;
                    res.kind   = wavhc_pkg::KIND_REJECT;
                    res.error_code = wavhc_pkg::ERR_RIFF;
                end
                else if (e_fp == 4'd11)
                begin
                    if (tag_sh_c != wavhc_pkg::TAG_WAVE)
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res.kind   = wavhc_pkg::KIND_REJECT;
                        res.error_code = wavhc_pkg::ERR_WAVE;
                    end
                    else
                    begin
                        hc_next = 16'd12;
                        fg_next = 1'b0;
                        if (16'd12 >= cfg.header_limit)
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res.kind   = wavhc_pkg::KIND_REJECT;
                            res.error_code = wavhc_pkg::ERR_HDR_LIMIT;
                        end
                        else
                        begin
                            phase_next = PH_CHDR;
                            fp_next    = 4'd0;
                            tag_next   = 32'd0;
                            cl_next    = 32'd0;
                        end
                    end
                end
                else
                begin
                    fp_next = e_fp + 4'd1;
                end
            end

            PH_CHDR:
            begin
                if (e_fp < 4'd4)
                begin
                    tag_next = tag_sh_c;
                    fp_next  = e_fp + 4'd1;
                end
                else
                begin
                    cl_next = size_c;
                    if (e_fp < 4'd7)
                    begin
                        fp_next = e_fp + 4'd1;
                    end
                    else if (e_tag == wavhc_pkg::TAG_DATA)
                    begin
                        hc_next   = hc8_c;
                        res_valid = 1'b1;
                        if (!e_fg)
                        begin
                            phase_next = PH_IDLE;
                            res.kind   = wavhc_pkg::KIND_REJECT;
                            res.error_code = wavhc_pkg::ERR_FORMAT;
                        end
                        else if (over_c || size_c == 32'd0 || size_c[0] ||
                                 size_c > {8'd0, cfg.max_data_bytes})
                        begin
                            phase_next = PH_IDLE;
                            res.kind   = wavhc_pkg::KIND_REJECT;
                            res.error_code = wavhc_pkg::ERR_DATA_SIZE;
                        end
                        else
                        begin
                            left_next  = size_c[23:0];
                            phase_next = PH_DATA;
                            fp_next    = 4'd0;
                            res.kind   = wavhc_pkg::KIND_HEADER;
                            res.data_bytes = size_c[23:0];
                        end
                    end
                    else if (over_c || size_c > {20'd0, cfg.max_chunk_bytes})
                    begin
                        hc_next    = hc8_c;
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res.kind   = wavhc_pkg::KIND_REJECT;
                        res.error_code = wavhc_pkg::ERR_CHUNK_BIG;
                    end
                    else
                    begin
                        // body plus pad byte; size is at most 4095 here
                        in_fmt_next = (e_tag == wavhc_pkg::TAG_FMT);
                        if (in_fmt_next)
                        begin
                            fso_next  = (size_c >= 32'd16);
                            cap_next  = 64'd0;
                            bits_next = 16'd0;
                        end
                        cl_next    = {19'd0, len_c};
                        hc_next    = (hsum_c > 18'd65535) ? 16'hFFFF : hsum_c[15:0];
                        bp_next    = 5'd0;
                        phase_next = PH_BODY;
                        if (len_c == 13'd0)
                        begin
                            // empty body ends at the header; an empty fmt fails
                            if (in_fmt_next)
                                fg_next = 1'b0;
                            if (hc_next >= cfg.header_limit)
                            begin
                                phase_next = PH_IDLE;
                                res_valid  = 1'b1;
                                res.kind   = wavhc_pkg::KIND_REJECT;
                                res.error_code = wavhc_pkg::ERR_HDR_LIMIT;
                            end
                            else
                            begin
                                phase_next = PH_CHDR;
                                fp_next    = 4'd0;
                                tag_next   = 32'd0;
                                cl_next    = 32'd0;
                            end
                        end
                    end
                end
            end

            PH_BODY:
            begin
                if (e_in_fmt && e_bp < 5'd16)
                begin
                    if (e_bp < 5'd8)
                        cap_next[{e_bp[2:0], 3'b000} +: 8] = byte_in;
                    else if (e_bp == 5'd14)
                        bits_next[7:0] = byte_in;
                    else if (e_bp == 5'd15)
                        bits_next[15:8] = byte_in;
                end
                if (e_bp < 5'd16)
                    bp_next = e_bp + 5'd1;
                if (e_cl != 32'd0)
                    cl_next = e_cl - 32'd1;
                if (cl_next == 32'd0)
                begin
                    if (e_in_fmt)
                        fg_next = e_fso && cap_next[15:0] == 16'd1 &&
                                  cap_next[31:16] == 16'd1 &&
                                  cap_next[63:32] == cfg.expected_rate &&
                                  bits_next == 16'd16;
                    if (e_hc >= cfg.header_limit)
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res.kind   = wavhc_pkg::KIND_REJECT;
                        res.error_code = wavhc_pkg::ERR_HDR_LIMIT;
                    end
                    else
                    begin
                        phase_next = PH_CHDR;
                        fp_next    = 4'd0;
                        tag_next   = 32'd0;
                        cl_next    = 32'd0;
                    end
                end
            end

            PH_DATA:
            begin
                if (e_fp == 4'd0)
                begin
                    low_next = byte_in;
                    fp_next  = 4'd1;
                end
                else
                begin
                    fp_next    = 4'd0;
                    left_next  = (e_left >= 24'd2) ? e_left - 24'd2 : 24'd0;
                    res_valid  = 1'b1;
                    res.kind   = wavhc_pkg::KIND_SAMPLE;
                    res.sample = {byte_in, e_low};
                    res.last   = (left_next == 24'd0);
                    if (res.last)
                        phase_next = PH_IDLE;
                end
            end

            default:
            begin
                phase_next = e_phase;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RIFF;
            fp_reg     <= 4'd0;
            tag_reg    <= 32'd0;
            cl_reg     <= 32'd0;
            bp_reg     <= 5'd0;
            hc_reg     <= 16'd0;
            fg_reg     <= 1'b0;
            in_fmt_reg <= 1'b0;
            fso_reg    <= 1'b0;
            cap_reg    <= 64'd0;
            bits_reg   <= 16'd0;
            left_reg   <= 24'd0;
            low_reg    <= 8'd0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            fp_reg     <= fp_next;
            tag_reg    <= tag_next;
            cl_reg     <= cl_next;
            bp_reg     <= bp_next;
            hc_reg     <= hc_next;
            fg_reg     <= fg_next;
            in_fmt_reg <= in_fmt_next;
            fso_reg    <= fso_next;
            cap_reg    <= cap_next;
            bits_reg   <= bits_next;
            left_reg   <= left_next;
            low_reg    <= low_next;
        end
    end

endmodule

// ===== rtl/core/wav_header_check_and_unpack.sv =====
// WAV header check and unpack: RIFF/WAVE check, chunk walk, fmt check, sample unpack.
// Throughput: one byte per clock, sustained, when the output side does not stall.
// Path: an accepted byte goes through one input register stage, then the parse step feeds its
//   result (if any) into the result register that drives out_valid; an output stall can hold it.
// Reset (rst_n, async, active low): parser expects byte 0 of a file, config regs take defaults.
// Depends on wavhc_pkg, wavhc_cfg, wavhc_parse.
module wav_header_check_and_unpack
#(
    parameter int SIZE_FIELD_BITS = wavhc_pkg::SIZE_FIELD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [31:0]        wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               first,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [2:0]         error_code,
    output logic [23:0]        data_bytes,
    output logic signed [15:0] sample,
    output logic               last
);

    wavhc_pkg::cfg_t cfg;
    wavhc_pkg::res_t res;
    wavhc_pkg::res_t res_reg;
    logic            res_valid;
    logic            in_vld_reg;
    logic [7:0]      byte_reg;
    logic            first_reg;
    logic            out_vld_reg;
    logic            step_en;

    // the held request advances when the result register is free or draining
    assign step_en  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !step_en;

    wavhc_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    wavhc_parse
    #(
        .SIZE_FIELD_BITS (SIZE_FIELD_BITS)
    )
    u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .byte_in   (byte_reg),
        .first_in  (first_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_vld_reg <= in_valid;
            if (out_vld_reg && !out_stall)
                out_vld_reg <= 1'b0;
            if (step_en && res_valid)
                out_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg  <= data_byte;
            first_reg <= first;
        end
        if (step_en && res_valid)
            res_reg <= res;
    end

    assign out_valid  = out_vld_reg;
    assign kind       = res_reg.kind;
    assign error_code = res_reg.error_code;
    assign data_bytes = res_reg.data_bytes;
    assign sample     = res_reg.sample;
    assign last       = res_reg.last;

endmodule
